[hdl/l2fp_pkg.sv]
`default_nettype none
package l2fp_pkg;

    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 13;
    localparam int POS_W    = 4;
    localparam int IDX_W    = 4;
    localparam int LOW_W    = 12;
    localparam int BASE_W   = 8;
    localparam int DIFF_W   = 5;

    localparam logic FMT_UINT  = 1'b0;
    localparam logic FMT_FIX88 = 1'b1;

    localparam logic [RESULT_W-1:0] FIX88_OFFSET = 13'h800;

    typedef struct packed {
        logic [VALUE_W-1:0] x;
        logic [POS_W-1:0]   pos;
        logic               kill;
        logic               fmt;
    } lzd_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LOW_W-1:0] low;
        logic [POS_W-1:0] pos;
        logic             kill;
        logic             fmt;
    } norm_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [DIFF_W-1:0] diff;
        logic [LOW_W-1:0]  low;
        logic [POS_W-1:0]  pos;
        logic              kill;
        logic              fmt;
    } frac_t;

    // 256*log2(1 + k/16)
    function automatic logic [8:0] frac_tab(input logic [4:0] k);
        logic [8:0] r;
        case (k)
            5'd0:    r = 9'h000;
            5'd1:    r = 9'h016;
            5'd2:    r = 9'h02b;
            5'd3:    r = 9'h03f;
            5'd4:    r = 9'h052;
            5'd5:    r = 9'h064;
            5'd6:    r = 9'h076;
            5'd7:    r = 9'h086;
            5'd8:    r = 9'h096;
            5'd9:    r = 9'h0a5;
            5'd10:   r = 9'h0b3;
            5'd11:   r = 9'h0c1;
            5'd12:   r = 9'h0cf;
            5'd13:   r = 9'h0dc;
            5'd14:   r = 9'h0e8;
            5'd15:   r = 9'h0f4;
            5'd16:   r = 9'h100;
            default: r = 9'h000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/l2fp_lzd.sv]
`default_nettype none
module l2fp_lzd (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [l2fp_pkg::VALUE_W-1:0]  x,
    input  wire logic                          fmt,
    output logic                               out_vld,
    output l2fp_pkg::lzd_t                     out_data
);

    logic                 vld_reg;
    l2fp_pkg::lzd_t       data_reg;
    l2fp_pkg::lzd_t       data_next;

    always_comb
    begin
        data_next.x    = x;
        data_next.fmt  = fmt;
        data_next.pos  = '0;
        for (int i = 1; i < l2fp_pkg::VALUE_W; i++)
        begin
            if (x[i])
            begin
                data_next.pos = l2fp_pkg::POS_W'(i);
            end
        end
        // zero or negative fixed-point input
        data_next.kill = (fmt == l2fp_pkg::FMT_FIX88) &&
                         ((x == '0) || x[l2fp_pkg::VALUE_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

[hdl/l2fp_norm.sv]
`default_nettype none
module l2fp_norm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_vld,
    input  wire l2fp_pkg::lzd_t  in_data,
    output logic                 out_vld,
    output l2fp_pkg::norm_t      out_data
);

    logic                           vld_reg;
    l2fp_pkg::norm_t                data_reg;
    l2fp_pkg::norm_t                data_next;
    logic [l2fp_pkg::POS_W:0]       shamt;
    logic [l2fp_pkg::VALUE_W-1:0]   n;

    always_comb
    begin
        // drop the leading one off the top
        shamt          = (l2fp_pkg::POS_W+1)'(l2fp_pkg::VALUE_W) - {1'b0, in_data.pos};
        n              = l2fp_pkg::VALUE_W'(in_data.x << shamt);
        data_next.idx  = n[l2fp_pkg::VALUE_W-1 -: l2fp_pkg::IDX_W];
        data_next.low  = n[l2fp_pkg::LOW_W-1:0];
        data_next.pos  = in_data.pos;
        data_next.kill = in_data.kill;
        data_next.fmt  = in_data.fmt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

[hdl/l2fp_frac.sv]
`default_nettype none
module l2fp_frac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_vld,
    input  wire l2fp_pkg::norm_t in_data,
    output logic                 out_vld,
    output l2fp_pkg::frac_t      out_data
);

    logic               vld_reg;
    l2fp_pkg::frac_t    data_reg;
    l2fp_pkg::frac_t    data_next;
    logic [8:0]         lo_ent;
    logic [8:0]         hi_ent;
    logic [8:0]         diff;

    always_comb
    begin
        lo_ent         = l2fp_pkg::frac_tab({1'b0, in_data.idx});
        hi_ent         = l2fp_pkg::frac_tab(5'({1'b0, in_data.idx}) + 5'd1);
        diff           = hi_ent - lo_ent;
        data_next.base = lo_ent[l2fp_pkg::BASE_W-1:0];
        data_next.diff = diff[l2fp_pkg::DIFF_W-1:0];
        data_next.low  = in_data.low;
        data_next.pos  = in_data.pos;
        data_next.kill = in_data.kill;
        data_next.fmt  = in_data.fmt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

[hdl/l2fp_out.sv]
`default_nettype none
module l2fp_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_vld,
    input  wire l2fp_pkg::frac_t                in_data,
    output logic                                out_vld,
    output logic                                out_fmt,
    output logic signed [l2fp_pkg::RESULT_W-1:0] result
);

    localparam int PROD_W = l2fp_pkg::LOW_W + l2fp_pkg::DIFF_W;

    logic                               vld_reg;
    logic                               fmt_reg;
    logic [l2fp_pkg::RESULT_W-1:0]      result_reg;
    logic [l2fp_pkg::RESULT_W-1:0]      result_next;
    logic [PROD_W-1:0]                  prod;
    logic [l2fp_pkg::BASE_W:0]          gf;
    logic [l2fp_pkg::RESULT_W-2:0]      ulog;

    always_comb
    begin
        prod = PROD_W'(in_data.low) * PROD_W'(in_data.diff);
        gf   = (l2fp_pkg::BASE_W+1)'(in_data.base) +
               (l2fp_pkg::BASE_W+1)'(prod[PROD_W-1:l2fp_pkg::LOW_W]);
        if (in_data.pos == '0)
        begin
            ulog = '0;
        end
        else
        begin
            ulog = {in_data.pos, gf[l2fp_pkg::BASE_W-1:0]};
        end
        if (in_data.fmt == l2fp_pkg::FMT_FIX88)
        begin
            if (in_data.kill)
            begin
                result_next = '0;
            end
            else
            begin
                result_next = {1'b0, ulog} - l2fp_pkg::FIX88_OFFSET;
            end
        end
        else
        begin
            result_next = {1'b0, ulog};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            fmt_reg    <= in_data.fmt;
        end
    end

    assign out_vld = vld_reg;
    assign out_fmt = fmt_reg;
    assign result  = result_reg;

endmodule
`default_nettype wire

[hdl/log2_fixed_point_table_interp_unit.sv]
// channel   direction  handshake            payload
// in        input      in_valid/in_stall    value[15:0]
// out       output     out_valid/out_stall  log_result[12:0] signed 5.8
// cfg       input      cfg_valid/cfg_ready  cfg_data[0] input format
//
// four register stages: leading-one search, normalize, table lookup, interpolate
// one beat per cycle while the output is not stalled
// a stalled output beat freezes the whole pipeline; in_stall follows it
// reset clears the valid bits and sets input format to signed 8.8
// cfg_ready is always high
`default_nettype none
module log2_fixed_point_table_interp_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [l2fp_pkg::VALUE_W-1:0]           value,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [l2fp_pkg::RESULT_W-1:0]        log_result,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic                                   cfg_data
);

    logic              fmt_reg;
    logic              en;
    logic              a_vld;
    l2fp_pkg::lzd_t    a_data;
    logic              b_vld;
    l2fp_pkg::norm_t   b_data;
    logic              c_vld;
    l2fp_pkg::frac_t   c_data;
    logic              d_fmt;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= l2fp_pkg::FMT_FIX88;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= cfg_data;
        end
    end

    l2fp_lzd u_lzd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .x        (value),
        .fmt      (fmt_reg),
        .out_vld  (a_vld),
        .out_data (a_data)
    );

    l2fp_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (a_vld),
        .in_data  (a_data),
        .out_vld  (b_vld),
        .out_data (b_data)
    );

    l2fp_frac u_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (b_vld),
        .in_data  (b_data),
        .out_vld  (c_vld),
        .out_data (c_data)
    );

    l2fp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_vld),
        .in_data  (c_data),
        .out_vld  (out_valid),
        .out_fmt  (d_fmt),
        .result   (log_result)
    );

    // an accepted beat reaches the output while out_stall stays low behind it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("accepted beat did not reach output");

    // unsigned mode never yields a negative log
    a_uint_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && d_fmt == l2fp_pkg::FMT_UINT) |-> !log_result[l2fp_pkg::RESULT_W-1])
        else $error("negative result in unsigned mode");

    // a beat held at the output keeps the pipeline behind it frozen
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && c_vld) |=> (c_vld && $stable(c_data)))
        else $error("pipeline moved under a stalled output");

endmodule
`default_nettype wire

[verif/log2_fixed_point_table_interp_unit_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module log2_fixed_point_table_interp_unit_test;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 290;
    localparam int PHASES      = 6;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [l2fp_pkg::VALUE_W-1:0]         value = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [l2fp_pkg::RESULT_W-1:0] log_result;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic                                 cfg_data = 1'b0;

    // 256*log2(1 + k/16)
    logic [8:0] frac_lut [0:16] = '{
        9'h000, 9'h016, 9'h02b, 9'h03f, 9'h052, 9'h064, 9'h076, 9'h086,
        9'h096, 9'h0a5, 9'h0b3, 9'h0c1, 9'h0cf, 9'h0dc, 9'h0e8, 9'h0f4, 9'h100
    };

    logic [l2fp_pkg::VALUE_W-1:0]  values_to_send [$];
    logic [l2fp_pkg::RESULT_W-1:0] logs_due [$];
    logic                          fmt_now = l2fp_pkg::FMT_FIX88;
    logic [l2fp_pkg::RESULT_W-1:0] want;
    int                            idle_pct = 0;
    int                            in_gap = 0;
    int                            out_gap = 0;
    int                            stuck = 0;
    int                            errors = 0;

    log2_fixed_point_table_interp_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .log_result (log_result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [l2fp_pkg::RESULT_W-1:0] log2_fix88(
        input logic [l2fp_pkg::VALUE_W-1:0] v,
        input logic fmt);
        logic [l2fp_pkg::VALUE_W-1:0]  n;
        int                            g;
        logic [3:0]                    k;
        logic [11:0]                   frac_low;
        logic [8:0]                    lo_e;
        logic [8:0]                    hi_e;
        logic [20:0]                   span;
        logic [8:0]                    frac;
        logic [l2fp_pkg::RESULT_W-1:0] r;
        n = v;
        g = 15;
        while (g > 0 && !n[15])
        begin
            n = n << 1;
            g--;
        end
        if (g == 0)
        begin
            r = '0;
        end
        else
        begin
            n = n << 1;
            k = n[15:12];
            frac_low = n[11:0];
            lo_e = frac_lut[k];
            hi_e = frac_lut[int'(k) + 1];
            span = frac_low * (hi_e - lo_e);
            frac = lo_e + 9'(span >> 12);
            r = {g[3:0], frac[7:0]};
        end
        if (fmt == l2fp_pkg::FMT_FIX88)
        begin
            if (v == '0 || v[15])
                r = '0;
            else
                r = r - 13'h800;
        end
        return r;
    endfunction

    function automatic logic [l2fp_pkg::VALUE_W-1:0] pick_value();
        logic [l2fp_pkg::VALUE_W-1:0] v;
        int                           p;
        case ($urandom_range(0, 3))
            0: v = l2fp_pkg::VALUE_W'($urandom);
            1, 2:
            begin
                p = $urandom_range(0, 15);
                v = 16'h1 << p;
                v = v | (l2fp_pkg::VALUE_W'($urandom) & (v - 16'h1));
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h8000;
                    3: v = 16'hffff;
                    4: v = 16'h7fff;
                    default: v = 16'h0100;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        while (values_to_send.size() != 0 || logs_due.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_format(input logic f);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= f;
        do
            @(posedge clk);
        while (!cfg_ready);
        fmt_now = f;
        cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (values_to_send.size() != 0)
            begin
                in_valid <= 1'b1;
                value <= values_to_send.pop_front();
                if ($urandom_range(0, 99) < idle_pct)
                    in_gap = $urandom_range(1, 8);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 99) < idle_pct)
                out_gap = $urandom_range(1, 8);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (in_valid && !in_stall)
                logs_due.push_back(log2_fix88(value, fmt_now));
            if (out_valid && !out_stall)
            begin
                if (logs_due.size() == 0)
                begin
                    $error("log_result: no beat expected, actual %0d", log_result);
                    errors++;
                end
                else
                begin
                    want = logs_due.pop_front();
                    if (log_result !== want)
                    begin
                        $error("log_result: expected %0d, actual %0d",
                               $signed(want), log_result);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (stuck < STUCK_LIMIT)
            @(posedge clk);
        $display("log2_fixed_point_table_interp_unit: mismatch");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // signed 8.8 after reset: zero, smallest positive, negatives, extremes
        values_to_send = '{16'h0000, 16'h0001, 16'h0002, 16'h0100, 16'h0180,
                           16'h00ff, 16'h7fff, 16'h8000, 16'hffff, 16'h5555,
                           16'haaaa, 16'h1fff};
        wait_idle();

        // unsigned: zero and one, top table interval, largest
        write_format(l2fp_pkg::FMT_UINT);
        values_to_send = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h1000,
                           16'h1fff, 16'hf000, 16'hffff, 16'h8000, 16'h7fff,
                           16'h8fff, 16'haaaa};
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_format(ph % 2 == 0 ? l2fp_pkg::FMT_FIX88 : l2fp_pkg::FMT_UINT);
            idle_pct = (ph == PHASES - 1) ? 0 : $urandom_range(5, 40);
            for (int i = 0; i < PHASE_ITEMS; i++)
                values_to_send.push_back(pick_value());
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("log2_fixed_point_table_interp_unit: match");
        else
            $display("log2_fixed_point_table_interp_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
